// ===== hdl/euler_to_quaternion_rotation_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the Euler angle to quaternion block
// Clocked, reset-qualified assertion shorthands; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef EULER_TO_QUATERNION_ROTATION_DEFINES_SVH
`define EULER_TO_QUATERNION_ROTATION_DEFINES_SVH

`ifndef SYNTHESIS
`define E2Q_ASSERT_CLKRST(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("e2q assertion failed");
`define E2Q_ASSERT(lbl, prop) `E2Q_ASSERT_CLKRST(lbl, i_clk, i_rst_n, prop)
`else
`define E2Q_ASSERT_CLKRST(lbl, clk, rstn, prop)
`define E2Q_ASSERT(lbl, prop)
`endif

`endif

// ===== hdl/e2q_pkg.sv =====
// ----------------------------------------------------------------------------
// e2q_pkg
// Shared types and constants of the Euler angle to quaternion block.
// ----------------------------------------------------------------------------
package e2q_pkg;

    localparam int ANGLE_IN_W = 16;
    localparam int CORDIC_XW  = 43;
    localparam int CORDIC_ZW  = 34;
    localparam int CORDIC_FRAC = 40;
    localparam int GRP_W      = 2;

    localparam logic [GRP_W-1:0] GRP_FIRST = 2'd0;
    localparam logic [GRP_W-1:0] GRP_LAST  = 2'd2;

    // Inverse CORDIC gain in Q32, moved up to 40 fraction bits.
    localparam logic signed [CORDIC_XW-1:0] CORDIC_X0 = 43'sd667681662976;

    // arctan(2^-i) in units of 2^32 per turn.
    localparam logic [31:0] ATAN_TURNS [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    // Pipeline control handed to every stage group.
    typedef struct packed {
        logic en;
        logic valid;
    } t_stage_ctl;

endpackage

// ===== hdl/e2q_cordic.sv =====
// ----------------------------------------------------------------------------
// e2q_cordic
// One lane: pipelined rotation CORDIC giving cosine and sine of half an angle.
// ----------------------------------------------------------------------------
module e2q_cordic import e2q_pkg::*; #(
    parameter int ANGLE_BITS  = 16,
    parameter int FRAC_BITS   = 16,
    parameter int TRIG_STAGES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_stage_ctl                    i_ctl,
    input  logic [ANGLE_IN_W-1:0]         i_angle,
    output logic                          o_valid,
    output logic signed [FRAC_BITS+1:0]   o_cos,
    output logic signed [FRAC_BITS+1:0]   o_sin
);

    localparam int W          = FRAC_BITS + 2;
    localparam int HALF_SHIFT = (ANGLE_BITS <= 31) ? (31 - ANGLE_BITS) : 0;
    localparam int RS         = CORDIC_FRAC - FRAC_BITS;
    localparam logic signed [CORDIC_XW-1:0] RND = 43'sd1 <<< (RS - 1);
    localparam logic signed [CORDIC_XW-1:0] ONE = 43'sd1 <<< FRAC_BITS;

    logic [31:0]                   raw32;
    logic [ANGLE_BITS-1:0]         a_raw;
    logic signed [CORDIC_ZW-1:0]   a_ext;
    logic signed [CORDIC_ZW-1:0]   z0;
    logic signed [CORDIC_XW-1:0]   xr;
    logic signed [CORDIC_XW-1:0]   yr;

    logic signed [CORDIC_XW-1:0] r_x [TRIG_STAGES+1];
    logic signed [CORDIC_XW-1:0] r_y [TRIG_STAGES+1];
    logic signed [CORDIC_ZW-1:0] r_z [TRIG_STAGES+1];
    logic                        r_v [TRIG_STAGES+1];
    logic signed [W-1:0]         r_cos;
    logic signed [W-1:0]         r_sin;
    logic                        r_out_v;

    // Bits above ANGLE_BITS are dropped, then the angle is halved into
    // 2^32 units per turn.
    always_comb begin
        raw32 = {{(32-ANGLE_IN_W){1'b0}}, i_angle};
        a_raw = raw32[ANGLE_BITS-1:0];
        a_ext = $signed({{(CORDIC_ZW-ANGLE_BITS){a_raw[ANGLE_BITS-1]}}, a_raw});
        if (ANGLE_BITS == 32) begin
            z0 = a_ext >>> 1;
        end else begin
            z0 = a_ext <<< HALF_SHIFT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_ctl.en) begin
            r_v[0] <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_x[0] <= CORDIC_X0;
            r_y[0] <= '0;
            r_z[0] <= z0;
        end
    end

    for (genvar i = 0; i < TRIG_STAGES; i++) begin : g_stage
        localparam logic signed [CORDIC_ZW-1:0] ATAN =
            $signed({{(CORDIC_ZW-32){1'b0}}, ATAN_TURNS[i % 32]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else if (i_ctl.en) begin
                r_v[i+1] <= r_v[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                if (!r_z[i][CORDIC_ZW-1]) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - ATAN;
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + ATAN;
                end
            end
        end
    end

    // Round half up to FRAC_BITS, then clamp to [-1, +1].
    always_comb begin
        xr = (r_x[TRIG_STAGES] + RND) >>> RS;
        yr = (r_y[TRIG_STAGES] + RND) >>> RS;
        if (xr > ONE) begin
            xr = ONE;
        end else if (xr < -ONE) begin
            xr = -ONE;
        end
        if (yr > ONE) begin
            yr = ONE;
        end else if (yr < -ONE) begin
            yr = -ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_ctl.en) begin
            r_out_v <= r_v[TRIG_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_cos <= xr[W-1:0];
            r_sin <= yr[W-1:0];
        end
    end

    assign o_valid = r_out_v;
    assign o_cos   = r_cos;
    assign o_sin   = r_sin;

endmodule

// ===== hdl/e2q_quat.sv =====
// ----------------------------------------------------------------------------
// e2q_quat
// Merges the three lanes' cosines and sines into the saturated quaternion.
// ----------------------------------------------------------------------------
module e2q_quat import e2q_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_stage_ctl                  i_ctl,
    input  logic signed [FRAC_BITS+1:0] i_cx,
    input  logic signed [FRAC_BITS+1:0] i_sx,
    input  logic signed [FRAC_BITS+1:0] i_cy,
    input  logic signed [FRAC_BITS+1:0] i_sy,
    input  logic signed [FRAC_BITS+1:0] i_cz,
    input  logic signed [FRAC_BITS+1:0] i_sz,
    output logic                        o_valid,
    output logic signed [FRAC_BITS+1:0] o_w,
    output logic signed [FRAC_BITS+1:0] o_x,
    output logic signed [FRAC_BITS+1:0] o_y,
    output logic signed [FRAC_BITS+1:0] o_z
);

    localparam int W = FRAC_BITS + 2;
    localparam logic signed [2*W-1:0] RND = (2*W)'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [W:0] HI = (W+1)'((64'sd1 <<< (W - 1)) - 64'sd1);
    localparam logic signed [W:0] LO = (W+1)'(-(64'sd1 <<< (W - 1)));

    // Product of two values in [-1, +1], rounded half up.
    function automatic logic signed [W-1:0] fmul(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
        logic signed [2*W-1:0] p;
        p = (2*W)'(a) * (2*W)'(b) + RND;
        p = p >>> FRAC_BITS;
        return p[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] sat(input logic signed [W:0] v);
        if (v > HI) begin
            return HI[W-1:0];
        end else if (v < LO) begin
            return LO[W-1:0];
        end
        return v[W-1:0];
    endfunction

    logic signed [W-1:0] r_cxcy, r_sxsy, r_sxcy, r_cxsy, r_cz, r_sz;
    logic signed [W-1:0] r_ccc, r_sss, r_scc, r_css, r_csc, r_scs, r_ccs, r_ssc;
    logic signed [W-1:0] r_w, r_x, r_y, r_z;
    logic [2:0]          r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_ctl.en) begin
            r_v <= {r_v[1:0], i_ctl.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_cxcy <= fmul(i_cx, i_cy);
            r_sxsy <= fmul(i_sx, i_sy);
            r_sxcy <= fmul(i_sx, i_cy);
            r_cxsy <= fmul(i_cx, i_sy);
            r_cz   <= i_cz;
            r_sz   <= i_sz;

            r_ccc <= fmul(r_cxcy, r_cz);
            r_sss <= fmul(r_sxsy, r_sz);
            r_scc <= fmul(r_sxcy, r_cz);
            r_css <= fmul(r_cxsy, r_sz);
            r_csc <= fmul(r_cxsy, r_cz);
            r_scs <= fmul(r_sxcy, r_sz);
            r_ccs <= fmul(r_cxcy, r_sz);
            r_ssc <= fmul(r_sxsy, r_cz);

            r_w <= sat((W+1)'(r_ccc) + (W+1)'(r_sss));
            r_x <= sat((W+1)'(r_scc) - (W+1)'(r_css));
            r_y <= sat((W+1)'(r_csc) + (W+1)'(r_scs));
            r_z <= sat((W+1)'(r_ccs) - (W+1)'(r_ssc));
        end
    end

    assign o_valid = r_v[2];
    assign o_w     = r_w;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;

endmodule

// ===== hdl/e2q_matrix.sv =====
// ----------------------------------------------------------------------------
// e2q_matrix
// Forms the nine rotation matrix entries from the quaternion.
// ----------------------------------------------------------------------------
module e2q_matrix import e2q_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_stage_ctl                  i_ctl,
    input  logic signed [FRAC_BITS+1:0] i_w,
    input  logic signed [FRAC_BITS+1:0] i_x,
    input  logic signed [FRAC_BITS+1:0] i_y,
    input  logic signed [FRAC_BITS+1:0] i_z,
    output logic                        o_valid,
    output logic signed [FRAC_BITS+1:0] o_w,
    output logic signed [FRAC_BITS+1:0] o_x,
    output logic signed [FRAC_BITS+1:0] o_y,
    output logic signed [FRAC_BITS+1:0] o_z,
    output logic signed [FRAC_BITS+1:0] o_entry [3][3]
);

    localparam int W  = FRAC_BITS + 2;
    localparam int PW = W + 2;
    localparam int EW = W + 5;
    localparam logic signed [2*W-1:0] RND = (2*W)'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [EW-1:0] ONE = EW'(1) <<< FRAC_BITS;
    localparam logic signed [EW-1:0] HI  = EW'((64'sd1 <<< (W - 1)) - 64'sd1);
    localparam logic signed [EW-1:0] LO  = EW'(-(64'sd1 <<< (W - 1)));

    function automatic logic signed [PW-1:0] fmul(input logic signed [W-1:0] a,
                                                  input logic signed [W-1:0] b);
        logic signed [2*W-1:0] p;
        p = (2*W)'(a) * (2*W)'(b) + RND;
        p = p >>> FRAC_BITS;
        return p[PW-1:0];
    endfunction

    function automatic logic signed [W-1:0] sat(input logic signed [EW-1:0] v);
        if (v > HI) begin
            return HI[W-1:0];
        end else if (v < LO) begin
            return LO[W-1:0];
        end
        return v[W-1:0];
    endfunction

    logic signed [PW-1:0] r_xx, r_yy, r_zz, r_xy, r_wz, r_wy, r_xz, r_yz, r_wx;
    logic signed [W-1:0]  r_w1, r_x1, r_y1, r_z1;
    logic signed [W-1:0]  r_w2, r_x2, r_y2, r_z2;
    logic signed [W-1:0]  r_e [3][3];
    logic [1:0]           r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_ctl.en) begin
            r_v <= {r_v[0], i_ctl.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_xx <= fmul(i_x, i_x);
            r_yy <= fmul(i_y, i_y);
            r_zz <= fmul(i_z, i_z);
            r_xy <= fmul(i_x, i_y);
            r_wz <= fmul(i_w, i_z);
            r_wy <= fmul(i_w, i_y);
            r_xz <= fmul(i_x, i_z);
            r_yz <= fmul(i_y, i_z);
            r_wx <= fmul(i_w, i_x);
            r_w1 <= i_w;
            r_x1 <= i_x;
            r_y1 <= i_y;
            r_z1 <= i_z;

            r_e[0][0] <= sat(ONE - ((EW'(r_yy) + EW'(r_zz)) <<< 1));
            r_e[1][0] <= sat((EW'(r_xy) - EW'(r_wz)) <<< 1);
            r_e[2][0] <= sat((EW'(r_wy) + EW'(r_xz)) <<< 1);
            r_e[0][1] <= sat((EW'(r_xy) + EW'(r_wz)) <<< 1);
            r_e[1][1] <= sat(ONE - ((EW'(r_xx) + EW'(r_zz)) <<< 1));
            r_e[2][1] <= sat((EW'(r_yz) - EW'(r_wx)) <<< 1);
            r_e[0][2] <= sat((EW'(r_xz) - EW'(r_wy)) <<< 1);
            r_e[1][2] <= sat((EW'(r_yz) + EW'(r_wx)) <<< 1);
            r_e[2][2] <= sat(ONE - ((EW'(r_xx) + EW'(r_yy)) <<< 1));
            r_w2 <= r_w1;
            r_x2 <= r_x1;
            r_y2 <= r_y1;
            r_z2 <= r_z1;
        end
    end

    assign o_valid = r_v[1];
    assign o_w     = r_w2;
    assign o_x     = r_x2;
    assign o_y     = r_y2;
    assign o_z     = r_z2;
    assign o_entry = r_e;

endmodule

// ===== hdl/euler_to_quaternion_rotation.sv =====
// Throughput: each input gives three output transfers, and the output channel
// takes one transfer a cycle while i_m_axis_tready is high; a new input is
// accepted only when the output is empty or its last column is handed over.
// Reset: i_rst_n is synchronous and active low; it clears all valid flags
// and the column counter, so nothing is presented after reset.
// ----------------------------------------------------------------------------
// euler_to_quaternion_rotation
// Three CORDIC lanes form half-angle cosines and sines; a merge stage builds
// the unit quaternion, then the rotation matrix is sent one column a transfer.
// ----------------------------------------------------------------------------
`include "euler_to_quaternion_rotation_defines.svh"

module euler_to_quaternion_rotation import e2q_pkg::*; #(
    parameter int ANGLE_BITS  = 16,
    parameter int FRAC_BITS   = 16,
    parameter int TRIG_STAGES = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    // angle_about_x, angle_about_y, angle_about_z
    input  logic [3*ANGLE_IN_W-1:0] i_s_axis_tdata,
    output logic                    o_m_axis_tvalid,
    input  logic                    i_m_axis_tready,
    // quat_w, quat_x, quat_y, quat_z, entry_first, entry_second, entry_third,
    // zero fill to whole bytes
    output logic [((7*(FRAC_BITS+2)+7)/8)*8-1:0] o_m_axis_tdata,
    // last_group
    output logic                    o_m_axis_tlast,
    // group_index
    output logic [GRP_W-1:0]        o_m_axis_tuser
);

    localparam int W       = FRAC_BITS + 2;
    localparam int M_DATA_W = ((7 * W + 7) / 8) * 8;

    // The whole pipeline moves as one: it advances whenever the output
    // holding register is empty or is handing over its last column.
    logic       adv;
    t_stage_ctl lane_ctl;
    t_stage_ctl quat_ctl;
    t_stage_ctl mat_ctl;

    logic                lane_v [3];
    logic signed [W-1:0] lane_cos [3];
    logic signed [W-1:0] lane_sin [3];

    logic                quat_v;
    logic signed [W-1:0] q_w, q_x, q_y, q_z;

    logic                mat_v;
    logic signed [W-1:0] m_w, m_x, m_y, m_z;
    logic signed [W-1:0] m_e [3][3];

    // Output holding register: the quaternion and all nine entries stay here
    // while the three column transfers go out.
    logic                r_hold_v;
    logic [GRP_W-1:0]    r_grp;
    logic signed [W-1:0] r_w, r_x, r_y, r_z;
    logic signed [W-1:0] r_e [3][3];

    logic signed [W-1:0] col_first, col_second, col_third;

    assign adv = !r_hold_v || (i_m_axis_tready && (r_grp == GRP_LAST));

    assign o_s_axis_tready = adv;
    assign lane_ctl = '{en: adv, valid: i_s_axis_tvalid};

    for (genvar l = 0; l < 3; l++) begin : g_lane
        e2q_cordic #(
            .ANGLE_BITS  (ANGLE_BITS),
            .FRAC_BITS   (FRAC_BITS),
            .TRIG_STAGES (TRIG_STAGES)
        ) u_cordic (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (lane_ctl),
            .i_angle (i_s_axis_tdata[l*ANGLE_IN_W +: ANGLE_IN_W]),
            .o_valid (lane_v[l]),
            .o_cos   (lane_cos[l]),
            .o_sin   (lane_sin[l])
        );
    end

    // All lanes run in lock step, so their valid flags always agree.
    assign quat_ctl = '{en: adv, valid: lane_v[0] & lane_v[1] & lane_v[2]};

    e2q_quat #(
        .FRAC_BITS (FRAC_BITS)
    ) u_quat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (quat_ctl),
        .i_cx    (lane_cos[0]),
        .i_sx    (lane_sin[0]),
        .i_cy    (lane_cos[1]),
        .i_sy    (lane_sin[1]),
        .i_cz    (lane_cos[2]),
        .i_sz    (lane_sin[2]),
        .o_valid (quat_v),
        .o_w     (q_w),
        .o_x     (q_x),
        .o_y     (q_y),
        .o_z     (q_z)
    );

    assign mat_ctl = '{en: adv, valid: quat_v};

    e2q_matrix #(
        .FRAC_BITS (FRAC_BITS)
    ) u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mat_ctl),
        .i_w     (q_w),
        .i_x     (q_x),
        .i_y     (q_y),
        .i_z     (q_z),
        .o_valid (mat_v),
        .o_w     (m_w),
        .o_x     (m_x),
        .o_y     (m_y),
        .o_z     (m_z),
        .o_entry (m_e)
    );

    // The column counter steps on every accepted transfer but the last and
    // restarts at the first column whenever the pipeline advances.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_v <= 1'b0;
            r_grp    <= GRP_FIRST;
        end else if (adv) begin
            r_hold_v <= mat_v;
            r_grp    <= GRP_FIRST;
        end else if (i_m_axis_tready) begin
            r_grp <= r_grp + GRP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_w <= m_w;
            r_x <= m_x;
            r_y <= m_y;
            r_z <= m_z;
            r_e <= m_e;
        end
    end

    always_comb begin
        unique case (r_grp)
            GRP_FIRST: begin
                col_first  = r_e[0][0];
                col_second = r_e[1][0];
                col_third  = r_e[2][0];
            end
            GRP_LAST: begin
                col_first  = r_e[0][2];
                col_second = r_e[1][2];
                col_third  = r_e[2][2];
            end
            default: begin
                col_first  = r_e[0][1];
                col_second = r_e[1][1];
                col_third  = r_e[2][1];
            end
        endcase
    end

    assign o_m_axis_tvalid = r_hold_v;
    assign o_m_axis_tlast  = (r_grp == GRP_LAST);
    assign o_m_axis_tuser  = r_grp;
    assign o_m_axis_tdata  = M_DATA_W'({col_third, col_second, col_first,
                                        r_z, r_y, r_x, r_w});

    // A first or middle column transfer moves on to the next column of the same item.
    `E2Q_ASSERT(a_grp_step, r_hold_v && i_m_axis_tready && (r_grp != GRP_LAST) |=>
        r_hold_v && (r_grp == $past(r_grp) + GRP_W'(1)))
    // The quaternion's w and z parts stay put across the columns of one item.
    `E2Q_ASSERT(a_quat_kept, r_hold_v && (r_grp != GRP_LAST) |=> $stable(r_w) && $stable(r_z))
    // The column counter never leaves the three valid groups.
    `E2Q_ASSERT(a_grp_range, r_grp != 2'd3)

endmodule
